>>> hw/rtl/i2cmq_pkg.sv
// Shared types, codes and helpers for the I2C master transaction queue.
package i2cmq_pkg;

	localparam int BUFFER_BYTES_DEF = 128;
	localparam int HEADER_BYTES_DEF = 12;
	localparam int QUEUE_DEPTH_DEF  = 16;

	// Slot sizes reach 255 + 12 rounded up; sums against the buffer need ten bits.
	localparam int SUM_W = 10;

	localparam logic [1:0] MODE_ENQ     = 2'd0;
	localparam logic [1:0] MODE_OUTCOME = 2'd1;
	localparam logic [1:0] MODE_STOP    = 2'd2;

	localparam logic [1:0] OP_WRITE      = 2'd0;
	localparam logic [1:0] OP_READ       = 2'd1;
	localparam logic [1:0] OP_WRITE_READ = 2'd2;

	localparam logic [1:0] KIND_REPLY    = 2'd0;
	localparam logic [1:0] KIND_START    = 2'd1;
	localparam logic [1:0] KIND_COMPLETE = 2'd2;

	localparam logic ENQ_ACCEPTED = 1'b0;
	localparam logic ENQ_NO_MEM   = 1'b1;

	localparam logic [1:0] BUS_OK         = 2'd0;
	localparam logic [1:0] BUS_DEV_ABSENT = 2'd1;

	typedef struct packed {
		logic [1:0]  mode;
		logic [1:0]  op_kind;
		logic [6:0]  dev_address;
		logic [7:0]  write_len;
		logic [7:0]  read_len;
		logic        notify;
		logic [15:0] request_tag;
		logic [1:0]  bus_status;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  result_kind;
		logic        enqueue_status;
		logic [1:0]  out_op_kind;
		logic [6:0]  out_address;
		logic [7:0]  out_write_len;
		logic [7:0]  out_read_len;
		logic [1:0]  final_status;
		logic [15:0] out_tag;
		logic        last_result;
	} result_t;

	// One queued transaction as it sits in the descriptor memory.
	typedef struct packed {
		logic [15:0] tag;
		logic        notify;
		logic [7:0]  read_len;
		logic [7:0]  write_len;
		logic [6:0]  address;
		logic [1:0]  op_kind;
	} desc_t;

	function automatic result_t make_reply(input logic status);
		result_t r;
		r = '0;
		r.result_kind    = KIND_REPLY;
		r.enqueue_status = status;
		return r;
	endfunction

	function automatic result_t make_start(input desc_t d);
		result_t r;
		r = '0;
		r.result_kind   = KIND_START;
		r.out_op_kind   = d.op_kind;
		r.out_address   = d.address;
		r.out_write_len = d.write_len;
		r.out_read_len  = d.read_len;
		return r;
	endfunction

	function automatic result_t make_completion(input desc_t d, input logic [1:0] status);
		result_t r;
		r = '0;
		r.result_kind   = KIND_COMPLETE;
		r.out_op_kind   = d.op_kind;
		r.out_address   = d.address;
		r.out_write_len = d.write_len;
		r.out_read_len  = (status == BUS_OK) ? d.read_len : 8'd0;
		r.final_status  = status;
		r.out_tag       = d.tag;
		r.last_result   = 1'b1;
		return r;
	endfunction

endpackage

>>> hw/rtl/i2c_master_transaction_queue_top.sv
// I2C master transaction queue: command sequencer around a descriptor memory.
//
// Commands enter on item when start is high and busy is low. An enqueue
// reserves header plus the larger length, rounded up to four bytes, and is
// answered accepted or out of memory; a bus outcome or a stop seen drives the
// head transaction. Each result beat sits on result for exactly one cycle,
// marked by result_valid; last_result marks the final beat of a command.
// The receiver cannot stall, so nothing is ever held back.
// busy stays high through ST_EXEC for every command, also through ST_EMIT2
// when an enqueue issues a start, and through ST_WAIT and ST_ISSUE when a
// stop frees the head and issues the next one: the descriptor memory has
// one registered read port addressed by the head, and a new head must be
// read from it before its start can be issued. The user must write
// retry_limit through cfg_we and cfg_data only while the block is idle; the
// block itself does not enforce this. Asynchronous reset empties the queue,
// frees the engine, clears the limit; memory contents are not cleared, and
// data read from memory is used only while the queue holds entries.
module i2c_master_transaction_queue_top
	import i2cmq_pkg::*;
#(
	parameter int BUFFER_BYTES = BUFFER_BYTES_DEF,
	parameter int HEADER_BYTES = HEADER_BYTES_DEF,
	parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  in_item_t   item,
	output logic       result_valid,
	output result_t    result,
	input  logic       cfg_we,
	input  logic [3:0] cfg_data
);

	localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int SW = IW + 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_EMIT2,
		ST_WAIT,
		ST_ISSUE
	} state_t;

	typedef enum logic [1:0] {
		ENG_FREE,
		ENG_PENDING,
		ENG_CLOSING
	} eng_t;

	state_t        state_q, state_d;
	eng_t          eng_q, eng_d;
	logic [4:0]    tries_q, tries_d;
	logic [7:0]    used_q, used_d;
	logic [IW-1:0] head_q, head_d;
	logic [CW-1:0] count_q, count_d;
	logic [3:0]    limit_q;
	in_item_t      item_q, item_d;
	result_t       res_q, res_d;
	result_t       res2_q, res2_d;
	logic          res_valid_q, res_valid_d;
	desc_t         rd_q;

	desc_t         mem [QUEUE_DEPTH];
	logic          mem_we;
	logic [IW-1:0] mem_waddr;
	desc_t         new_desc;

	logic [1:0]       enq_op;
	logic [7:0]       enq_wl, enq_rl, enq_max;
	logic [SUM_W-1:0] enq_need, stop_len;
	logic [7:0]       stop_max;
	logic             enq_fit;
	logic [SW-1:0]    tail_sum;
	logic [4:0]       tries_inc;

	// Normalize the request, size its slot and the head's slot, and find the tail address.
	always_comb begin
		enq_op = (item_q.op_kind == 2'd3) ? OP_WRITE_READ : item_q.op_kind;
		enq_wl = (enq_op == OP_READ) ? 8'd0 : item_q.write_len;
		enq_rl = (enq_op == OP_WRITE) ? 8'd0 : item_q.read_len;
		enq_max = (enq_wl > enq_rl) ? enq_wl : enq_rl;
		enq_need = (SUM_W'(enq_max) + SUM_W'(HEADER_BYTES) + SUM_W'(3)) & ~SUM_W'(3);
		enq_fit = (count_q < CW'(QUEUE_DEPTH))
			&& ((SUM_W'(used_q) + enq_need) <= SUM_W'(BUFFER_BYTES));
		tail_sum = SW'(head_q) + SW'(count_q);
		if (tail_sum >= SW'(QUEUE_DEPTH)) begin
			tail_sum = tail_sum - SW'(QUEUE_DEPTH);
		end
		mem_waddr = tail_sum[IW-1:0];
		new_desc.op_kind   = enq_op;
		new_desc.address   = item_q.dev_address;
		new_desc.write_len = enq_wl;
		new_desc.read_len  = enq_rl;
		new_desc.notify    = item_q.notify;
		new_desc.tag       = item_q.request_tag;
		stop_max = (rd_q.write_len > rd_q.read_len) ? rd_q.write_len : rd_q.read_len;
		stop_len = (SUM_W'(stop_max) + SUM_W'(HEADER_BYTES) + SUM_W'(3)) & ~SUM_W'(3);
		tries_inc = tries_q + 5'd1;
	end

	always_comb begin
		state_d     = state_q;
		eng_d       = eng_q;
		tries_d     = tries_q;
		used_d      = used_q;
		head_d      = head_q;
		count_d     = count_q;
		item_d      = item_q;
		res_d       = res_q;
		res2_d      = res2_q;
		res_valid_d = 1'b0;
		mem_we      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					item_d  = item;
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_d = ST_IDLE;
				case (item_q.mode)
					MODE_ENQ: begin
						res_valid_d = 1'b1;
						if (enq_fit) begin
							mem_we  = 1'b1;
							count_d = count_q + CW'(1);
							used_d  = 8'(SUM_W'(used_q) + enq_need);
							res_d   = make_reply(ENQ_ACCEPTED);
							if (eng_q == ENG_FREE) begin
								// An empty queue has no head in memory yet: forward the new entry.
								res2_d = make_start((count_q == '0) ? new_desc : rd_q);
								res2_d.last_result = 1'b1;
								eng_d   = ENG_PENDING;
								tries_d = 5'd0;
								state_d = ST_EMIT2;
							end else begin
								res_d.last_result = 1'b1;
							end
						end else begin
							res_d = make_reply(ENQ_NO_MEM);
							res_d.last_result = 1'b1;
						end
					end
					MODE_OUTCOME: begin
						if (eng_q == ENG_PENDING && count_q != '0) begin
							if (item_q.bus_status == BUS_DEV_ABSENT
								&& tries_inc <= {1'b0, limit_q}) begin
								tries_d = tries_inc;
								res_d = make_start(rd_q);
								res_d.last_result = 1'b1;
								res_valid_d = 1'b1;
							end else begin
								if (item_q.bus_status == BUS_DEV_ABSENT) begin
									tries_d = tries_inc;
								end
								eng_d = ENG_CLOSING;
								if (rd_q.notify) begin
									res_d = make_completion(rd_q, item_q.bus_status);
									res_valid_d = 1'b1;
								end
							end
						end
					end
					MODE_STOP: begin
						if (eng_q == ENG_CLOSING && count_q != '0) begin
							used_d = (SUM_W'(used_q) > stop_len) ? 8'(SUM_W'(used_q) - stop_len)
								: 8'd0;
							head_d = (head_q == IW'(QUEUE_DEPTH - 1)) ? '0 : head_q + IW'(1);
							count_d = count_q - CW'(1);
							eng_d = ENG_FREE;
							// The next head is read from memory once the head pointer has moved.
							if (count_q > CW'(1)) begin
								state_d = ST_WAIT;
							end
						end
					end
					default: begin
					end
				endcase
			end
			ST_EMIT2: begin
				res_d       = res2_q;
				res_valid_d = 1'b1;
				state_d     = ST_IDLE;
			end
			ST_WAIT: begin
				state_d = ST_ISSUE;
			end
			ST_ISSUE: begin
				res_d = make_start(rd_q);
				res_d.last_result = 1'b1;
				res_valid_d = 1'b1;
				eng_d   = ENG_PENDING;
				tries_d = 5'd0;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			eng_q       <= ENG_FREE;
			tries_q     <= 5'd0;
			used_q      <= 8'd0;
			head_q      <= '0;
			count_q     <= '0;
			limit_q     <= 4'd0;
			item_q      <= '0;
			res_q       <= '0;
			res2_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			eng_q       <= eng_d;
			tries_q     <= tries_d;
			used_q      <= used_d;
			head_q      <= head_d;
			count_q     <= count_d;
			item_q      <= item_d;
			res_q       <= res_d;
			res2_q      <= res2_d;
			res_valid_q <= res_valid_d;
			if (cfg_we) begin
				limit_q <= cfg_data;
			end
		end
	end

	// Descriptor memory: one write port at the tail, one registered read port at the head.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= new_desc;
		end
		rd_q <= mem[head_q];
	end

	assign busy         = (state_q != ST_IDLE);
	assign result_valid = res_valid_q;
	assign result       = res_q;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted command did not raise busy");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(QUEUE_DEPTH))
		else $error("queue count beyond depth");

	a_bytes_bound: assert property (@(posedge clk) disable iff (!arst_n)
		SUM_W'(used_q) <= SUM_W'(BUFFER_BYTES))
		else $error("reserved bytes beyond buffer size");

	a_engine_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		eng_q != ENG_FREE |-> count_q != '0)
		else $error("engine busy with an empty queue");

	a_beat_follows: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.last_result |=> result_valid)
		else $error("non-final result beat not followed by another beat");

endmodule
